[rtl/core/ipv4_udp_header_parser_core_macros.svh]
// Assertion helpers shared by the parser core modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IPV4_UDP_HEADER_PARSER_CORE_MACROS_SVH
`define IPV4_UDP_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define IUHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IUHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/iuhp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iuhp_pkg
// Types, codes and header offsets for the IPv4/UDP header parser core.
// ----------------------------------------------------------------------------
package iuhp_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SKIP      = 3'd1,
        ST_SHORT_IP  = 3'd2,
        ST_NOT_V4    = 3'd3,
        ST_OPTIONS   = 3'd4,
        ST_FRAGMENT  = 3'd5,
        ST_NOT_UDP   = 3'd6,
        ST_SHORT_UDP = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        DIR_INPUT    = 2'd0,
        DIR_OUTPUT   = 2'd1,
        DIR_INTERNAL = 2'd2
    } t_dir;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK_INDEX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UDP_PROTOCOL   = 1'd1;
    localparam logic [15:0] LOOPBACK_INDEX_RST = 16'd1;
    localparam logic [7:0]  UDP_PROTOCOL_RST   = 8'd17;

    // Header byte offsets and lengths
    localparam logic [15:0] OFS_VER_IHL   = 16'd0;
    localparam logic [15:0] OFS_FRAG_HI   = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO   = 16'd7;
    localparam logic [15:0] OFS_PROTO     = 16'd9;
    localparam logic [15:0] OFS_SRC_ADDR  = 16'd12;
    localparam logic [15:0] OFS_DST_ADDR  = 16'd16;
    localparam logic [15:0] OFS_SRC_PORT  = 16'd20;
    localparam logic [15:0] OFS_DST_PORT  = 16'd22;
    localparam logic [15:0] OFS_UDP_END   = 16'd24;
    localparam logic [15:0] IP_HDR_LEN    = 16'd20;
    localparam logic [15:0] FULL_HDR_LEN  = 16'd28;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  IHL_WORDS     = 4'd5;
    localparam logic [7:0]  FRAG_HI_MASK  = 8'h3F;

    typedef struct packed {
        logic [15:0] loopback_index;
        logic [7:0]  udp_protocol;
    } t_cfg;

    // One classified packet, before field masking
    typedef struct packed {
        t_status     status;
        t_dir        direction;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] byte_count;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    // Result queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage
`default_nettype wire

[rtl/core/iuhp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iuhp_if
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface iuhp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packet_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] in_device;
    logic [15:0] out_device;

    modport source (output valid, packet_byte, first_byte, last_byte, in_device,
                    out_device, input ready);
    modport sink   (input valid, packet_byte, first_byte, last_byte, in_device,
                    out_device, output ready);
endinterface

interface iuhp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  direction;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  protocol_number;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] payload_length;

    modport source (output valid, status, direction, source_address,
                    destination_address, protocol_number, source_port,
                    destination_port, payload_length, input ready);
    modport sink   (input valid, status, direction, source_address,
                    destination_address, protocol_number, source_port,
                    destination_port, payload_length, output ready);
endinterface
`default_nettype wire

[rtl/core/ipv4_udp_header_parser_core.sv]
// A report is written into the result queue on the edge that accepts its last byte,
// then loaded into the output register once that register is empty or its report is taken.
// Throughput: one packet byte per cycle unless stalled; the intake counter takes every accepted byte.
// The input stalls only while the two-entry result queue is full.
// Reset (synchronous, active low) clears byte count, status, queue and output
// valid, and sets loopback_index to 1 and udp_protocol to 17.
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_udp_header_parser_core
// IPv4/UDP header parser: classifies one packet per last byte and reports
// status, direction, addresses, protocol, ports and payload length.
// ----------------------------------------------------------------------------
module ipv4_udp_header_parser_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [iuhp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [iuhp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    iuhp_in_if.sink                           i_in,
    iuhp_out_if.source                        o_out
);

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [15:0]     r_loopback_index;
    logic [7:0]      r_udp_protocol;
    iuhp_pkg::t_cfg  w_cfg;

    // Intake to queue, queue to output stage
    iuhp_pkg::t_push w_push;
    iuhp_pkg::t_rec  w_qdata;
    logic            w_full;
    logic            w_empty;
    logic            w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loopback_index <= iuhp_pkg::LOOPBACK_INDEX_RST;
            r_udp_protocol   <= iuhp_pkg::UDP_PROTOCOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                iuhp_pkg::CFG_LOOPBACK_INDEX: begin
                    r_loopback_index <= i_cfg_data[15:0];
                end
                iuhp_pkg::CFG_UDP_PROTOCOL: begin
                    r_udp_protocol <= i_cfg_data[7:0];
                end
                default: begin
                    // ignore writes to unused indexes
                end
            endcase
        end
    end

    assign w_cfg.loopback_index = r_loopback_index;
    assign w_cfg.udp_protocol   = r_udp_protocol;

    // Front: accept bytes, track the header and push one record per packet
    iuhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    // Queue: hold finished records so intake keeps running during output stalls
    iuhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_qdata)
    );

    // Back: mask fields by status and drive the result channel
    iuhp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_data  (w_qdata),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[rtl/core/iuhp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iuhp_front
// Byte intake: counts bytes, checks the header and captures its fields.
// ----------------------------------------------------------------------------
module iuhp_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  iuhp_pkg::t_cfg i_cfg,
    iuhp_in_if.sink        i_in,
    input  wire            i_full,
    output iuhp_pkg::t_push o_push
);

    logic [15:0]       r_byte_count, n_byte_count;
    iuhp_pkg::t_status r_status, n_status;
    iuhp_pkg::t_dir    r_dir, n_dir;
    logic [31:0]       r_src_addr, n_src_addr;
    logic [31:0]       r_dst_addr, n_dst_addr;
    logic [7:0]        r_proto, n_proto;
    logic [15:0]       r_src_port, n_src_port;
    logic [15:0]       r_dst_port, n_dst_port;

    logic [15:0]       w_cnt;
    iuhp_pkg::t_status w_stat;
    iuhp_pkg::t_status w_final;
    logic [7:0]        w_b;
    logic              w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_b        = i_in.packet_byte;

    always_comb begin
        w_cnt  = r_byte_count;
        w_stat = r_status;
        n_dir  = r_dir;
        if (i_in.first_byte) begin
            w_cnt  = '0;
            w_stat = iuhp_pkg::ST_OK;
            if (i_in.in_device != 16'd0) begin
                n_dir = iuhp_pkg::DIR_INPUT;
                if (i_in.in_device == i_cfg.loopback_index) begin
                    w_stat = iuhp_pkg::ST_SKIP;
                end
            end else begin
                n_dir = (i_in.out_device != i_cfg.loopback_index) ?
                        iuhp_pkg::DIR_OUTPUT : iuhp_pkg::DIR_INTERNAL;
            end
        end

        n_status   = w_stat;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_proto    = r_proto;
        n_src_port = r_src_port;
        n_dst_port = r_dst_port;

        // Record only the first fault of a packet
        if (w_stat != iuhp_pkg::ST_SKIP) begin
            if (w_cnt == iuhp_pkg::OFS_VER_IHL) begin
                if (w_b[7:4] != iuhp_pkg::IP_VERSION) begin
                    if (w_stat == iuhp_pkg::ST_OK) n_status = iuhp_pkg::ST_NOT_V4;
                end else if (w_b[3:0] != iuhp_pkg::IHL_WORDS) begin
                    if (w_stat == iuhp_pkg::ST_OK) n_status = iuhp_pkg::ST_OPTIONS;
                end
            end else if (w_cnt == iuhp_pkg::OFS_FRAG_HI) begin
                if ((w_b & iuhp_pkg::FRAG_HI_MASK) != 8'd0) begin
                    if (w_stat == iuhp_pkg::ST_OK) n_status = iuhp_pkg::ST_FRAGMENT;
                end
            end else if (w_cnt == iuhp_pkg::OFS_FRAG_LO) begin
                if (w_b != 8'd0) begin
                    if (w_stat == iuhp_pkg::ST_OK) n_status = iuhp_pkg::ST_FRAGMENT;
                end
            end else if (w_cnt == iuhp_pkg::OFS_PROTO) begin
                n_proto = w_b;
                if (w_b != i_cfg.udp_protocol) begin
                    if (w_stat == iuhp_pkg::ST_OK) n_status = iuhp_pkg::ST_NOT_UDP;
                end
            end else if (w_cnt >= iuhp_pkg::OFS_SRC_ADDR && w_cnt < iuhp_pkg::OFS_DST_ADDR) begin
                n_src_addr = {r_src_addr[23:0], w_b};
            end else if (w_cnt >= iuhp_pkg::OFS_DST_ADDR && w_cnt < iuhp_pkg::OFS_SRC_PORT) begin
                n_dst_addr = {r_dst_addr[23:0], w_b};
            end else if (w_cnt >= iuhp_pkg::OFS_SRC_PORT && w_cnt < iuhp_pkg::OFS_DST_PORT) begin
                n_src_port = {r_src_port[7:0], w_b};
            end else if (w_cnt >= iuhp_pkg::OFS_DST_PORT && w_cnt < iuhp_pkg::OFS_UDP_END) begin
                n_dst_port = {r_dst_port[7:0], w_b};
            end
        end

        // Saturate the count on very long packets
        n_byte_count = (w_cnt == iuhp_pkg::COUNT_MAX) ? w_cnt : w_cnt + 16'd1;

        if (w_stat == iuhp_pkg::ST_SKIP) begin
            w_final = iuhp_pkg::ST_SKIP;
        end else if (n_byte_count < iuhp_pkg::IP_HDR_LEN) begin
            w_final = iuhp_pkg::ST_SHORT_IP;
        end else if (n_status != iuhp_pkg::ST_OK) begin
            w_final = n_status;
        end else if (n_byte_count < iuhp_pkg::FULL_HDR_LEN) begin
            w_final = iuhp_pkg::ST_SHORT_UDP;
        end else begin
            w_final = iuhp_pkg::ST_OK;
        end
    end

    always_comb begin
        o_push.valid          = w_accept && i_in.last_byte;
        o_push.rec.status     = w_final;
        o_push.rec.direction  = n_dir;
        o_push.rec.src_addr   = n_src_addr;
        o_push.rec.dst_addr   = n_dst_addr;
        o_push.rec.proto      = n_proto;
        o_push.rec.src_port   = n_src_port;
        o_push.rec.dst_port   = n_dst_port;
        o_push.rec.byte_count = n_byte_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_status     <= iuhp_pkg::ST_OK;
            r_dir        <= iuhp_pkg::DIR_INPUT;
        end else if (w_accept) begin
            r_dir <= n_dir;
            if (i_in.last_byte) begin
                r_byte_count <= '0;
                r_status     <= iuhp_pkg::ST_OK;
            end else begin
                r_byte_count <= n_byte_count;
                r_status     <= n_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_proto    <= n_proto;
            r_src_port <= n_src_port;
            r_dst_port <= n_dst_port;
        end
    end

endmodule
`default_nettype wire

[rtl/core/iuhp_queue.sv]
`default_nettype none
`include "ipv4_udp_header_parser_core_macros.svh"
// ----------------------------------------------------------------------------
// iuhp_queue
// Short result queue between intake and output stages.
// ----------------------------------------------------------------------------
module iuhp_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  iuhp_pkg::t_push i_push,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_empty,
    output iuhp_pkg::t_rec  o_data
);

    iuhp_pkg::t_rec                 r_mem [iuhp_pkg::QDEPTH];
    logic [iuhp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [iuhp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [iuhp_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == iuhp_pkg::QCNT_W'(iuhp_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) r_wr_ptr <= r_wr_ptr + iuhp_pkg::QPTR_W'(1);
            if (i_pop)        r_rd_ptr <= r_rd_ptr + iuhp_pkg::QPTR_W'(1);
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + iuhp_pkg::QCNT_W'(1);
            end else if (!i_push.valid && i_pop) begin
                r_count <= r_count - iuhp_pkg::QCNT_W'(1);
            end
        end
    end

    `IUHP_ASSERT_IMP(a_no_push_full, i_push.valid, !o_full, "push into full result queue")
    `IUHP_ASSERT_IMP(a_no_pop_empty, i_pop, !o_empty, "pop from empty result queue")
    `IUHP_ASSERT_NEXT(a_count_up, i_push.valid && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not advance on push")

endmodule
`default_nettype wire

[rtl/core/iuhp_back.sv]
`default_nettype none
`include "ipv4_udp_header_parser_core_macros.svh"
// ----------------------------------------------------------------------------
// iuhp_back
// Output stage: masks fields by status, computes payload length, registers.
// ----------------------------------------------------------------------------
module iuhp_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_empty,
    input  iuhp_pkg::t_rec i_data,
    output logic           o_pop,
    iuhp_out_if.source     o_out
);

    logic        r_valid;
    logic [2:0]  r_status, n_status;
    logic [1:0]  r_direction, n_direction;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [15:0] r_payload_len, n_payload_len;
    logic        w_hdr_ok;
    logic        w_ok;

    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    always_comb begin
        w_ok     = (i_data.status == iuhp_pkg::ST_OK);
        w_hdr_ok = w_ok || (i_data.status == iuhp_pkg::ST_NOT_UDP) ||
                   (i_data.status == iuhp_pkg::ST_SHORT_UDP);
        n_status      = i_data.status;
        n_direction   = (i_data.status == iuhp_pkg::ST_SKIP) ? iuhp_pkg::DIR_INPUT
                                                              : i_data.direction;
        n_src_addr    = w_hdr_ok ? i_data.src_addr : 32'd0;
        n_dst_addr    = w_hdr_ok ? i_data.dst_addr : 32'd0;
        n_proto       = w_hdr_ok ? i_data.proto : 8'd0;
        n_src_port    = w_ok ? i_data.src_port : 16'd0;
        n_dst_port    = w_ok ? i_data.dst_port : 16'd0;
        n_payload_len = w_ok ? (i_data.byte_count - iuhp_pkg::FULL_HDR_LEN) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status      <= n_status;
            r_direction   <= n_direction;
            r_src_addr    <= n_src_addr;
            r_dst_addr    <= n_dst_addr;
            r_proto       <= n_proto;
            r_src_port    <= n_src_port;
            r_dst_port    <= n_dst_port;
            r_payload_len <= n_payload_len;
        end
    end

    assign o_out.valid               = r_valid;
    assign o_out.status              = r_status;
    assign o_out.direction           = r_direction;
    assign o_out.source_address      = r_src_addr;
    assign o_out.destination_address = r_dst_addr;
    assign o_out.protocol_number     = r_proto;
    assign o_out.source_port         = r_src_port;
    assign o_out.destination_port    = r_dst_port;
    assign o_out.payload_length      = r_payload_len;

    `IUHP_ASSERT_NEXT(a_pop_loads, o_pop, r_valid, "popped result not presented")
    `IUHP_ASSERT_IMP(a_skip_clean, r_valid && r_status == iuhp_pkg::ST_SKIP, r_direction == iuhp_pkg::DIR_INPUT && r_src_addr == 32'd0 && r_proto == 8'd0, "loopback skip carries data")
    `IUHP_ASSERT_IMP(a_fail_no_len, r_valid && r_status != iuhp_pkg::ST_OK, r_payload_len == 16'd0 && r_src_port == 16'd0 && r_dst_port == 16'd0, "failed packet carries UDP fields")

endmodule
`default_nettype wire
